### sv/qesm_pkg.sv
// Types, constants and codes shared by the quadrature encoder speed meter.
package qesm_pkg;

  localparam int KW = 36;
  localparam int DW = 32;
  localparam int QW = 38;
  localparam int OW = 32;

  localparam int CFG_IW = 8;
  localparam int CFG_DW = 16;

  localparam logic [KW-1:0] RPM_SCALE = 36'd15360000;
  localparam logic [KW-1:0] PI_KSCALE = 36'd51472000;

  localparam logic [15:0] CPR_RST  = 16'd364;
  localparam logic [9:0]  DIAM_RST = 10'd65;

  localparam logic [OW-1:0] OUT_MAX = 32'h7FFF_FFFF;
  localparam logic [OW-1:0] OUT_MIN = 32'h8000_0000;

  localparam logic [CFG_IW-1:0] CFG_CPR  = 8'd0;
  localparam logic [CFG_IW-1:0] CFG_DIAM = 8'd1;

  typedef enum logic [1:0] {
    KIND_EDGE   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSTART,
    ST_DWAIT,
    ST_LOAD,
    ST_SWAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  motor;
    logic        b_level;
    logic [15:0] period_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [OW-1:0] count_one;
    logic signed [OW-1:0] count_two;
    logic signed [OW-1:0] rpm_one;
    logic signed [OW-1:0] rpm_two;
    logic signed [OW-1:0] speed_one;
    logic signed [OW-1:0] speed_two;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] value;
  } cfg_beat_t;

endpackage

### sv/qesm_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface qesm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/qesm_div.sv
// Restoring divider, one quotient bit per cycle.
module qesm_div
  import qesm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [KW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [KW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int CW = $clog2(KW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q;
  logic [KW-1:0] quo_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, quo_q[KW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(KW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[KW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

### sv/qesm_scale.sv
// Bit-serial floor(mag * k / d) >> SH from k = q1 * d + r1, with sign and saturation.
module qesm_scale
  import qesm_pkg::*;
#(
  parameter int MW = 32,
  parameter int SH = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          neg_i,
  input  logic [MW-1:0] mag_i,
  input  logic [KW-1:0] q1_i,
  input  logic [DW-1:0] r1_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [OW-1:0] val_o
);

  localparam int CW = $clog2(MW + 1);
  localparam int SW = QW + 2;
  localparam int TW = DW + 2;

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [MW-1:0] mag_q;
  logic          neg_q;
  logic [QW-1:0] acc_q;
  logic [DW-1:0] rem_q;
  logic          sat_q;

  logic          bit_b;
  logic [TW-1:0] t;
  logic [TW-1:0] t_nx;
  logic [TW-1:0] den1;
  logic [TW-1:0] den2;
  logic [1:0]    qd;
  logic [KW-1:0] q1_sel;
  logic [SW-1:0] sum;
  logic          big;
  logic [OW-1:0] v;

  always_comb begin
    bit_b  = mag_q[MW-1];
    den1   = {2'b00, den_i};
    den2   = {1'b0, den_i, 1'b0};
    t      = {1'b0, rem_q, 1'b0} + (bit_b ? {2'b00, r1_i} : TW'(0));
    q1_sel = bit_b ? q1_i : '0;
    if (t >= den2) begin
      t_nx = t - den2;
      qd   = 2'd2;
    end else if (t >= den1) begin
      t_nx = t - den1;
      qd   = 2'd1;
    end else begin
      t_nx = t;
      qd   = 2'd0;
    end
    sum = SW'({acc_q, 1'b0}) + SW'(q1_sel) + SW'(qd);
  end

  always_comb begin
    big = sat_q || ((acc_q >> (OW - 1 + SH)) != '0);
    v   = OW'(acc_q >> SH);
    if (big) begin
      val_o = neg_q ? OUT_MIN : OUT_MAX;
    end else begin
      val_o = neg_q ? (~v + OW'(1)) : v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(MW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_i;
      neg_q <= neg_i;
      acc_q <= '0;
      rem_q <= '0;
      sat_q <= 1'b0;
    end else if (busy_q) begin
      mag_q <= mag_q << 1;
      acc_q <= sum[QW-1:0];
      rem_q <= t_nx[DW-1:0];
      sat_q <= sat_q || (sum[SW-1:QW] != '0);
    end
  end

  assign done_o = done_q;

endmodule

### sv/quadrature_encoder_speed_meter_unit.sv
// Top level of the two-channel quadrature encoder counter and speed meter.
//
//   channel  dir  payload      beat accepted when
//   item_i   in   in_item_t    item_i.valid && item_i.ready
//   cfg_i    in   cfg_beat_t   cfg_i.valid (ready is always high)
//   res_o    out  out_item_t   res_o.valid && res_o.ready
//
// Edge, clear and no-op items go from accept through the emit state into the result register.
// A sample with nonzero period runs a 36-step restoring divide, then one
// COUNT_BITS-step serial pass per motor.
// Reset loads counts_per_rev = 364 and a wheel diameter of 65 mm and zeroes all motor state.
// The result register decouples the sides: a new item is taken while a result waits.
module quadrature_encoder_speed_meter_unit
  import qesm_pkg::*;
#(
  parameter int NUM_MOTORS = 2,
  parameter int COUNT_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  qesm_stream_if.sink    item_i,
  qesm_stream_if.sink    cfg_i,
  qesm_stream_if.source  res_o
);

  localparam int MIW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int CB  = COUNT_BITS;

  state_e state_q, state_d;

  logic [15:0]    cpr_q;
  logic [9:0]     diam_q;
  logic [15:0]    cpr_eff;
  logic [DW-1:0]  d_q;
  logic [KW-1:0]  kspd_q;
  logic [MIW-1:0] cur_q;

  logic [CB-1:0] cnt_q  [NUM_MOTORS];
  logic [CB-1:0] prev_q [NUM_MOTORS];
  logic [OW-1:0] rpm_q  [NUM_MOTORS];
  logic [OW-1:0] spd_q  [NUM_MOTORS];

  out_item_t res_q, res_d;
  logic      res_vld_q;

  logic item_acc;
  logic item_rdy;
  logic div_go;
  logic scl_go;
  logic res_load;

  logic          rdiv_done, sdiv_done, div_done;
  logic [KW-1:0] q1r, q1s;
  logic [DW-1:0] r1r, r1s;

  logic          rscl_done, sscl_done, scl_done;
  logic [OW-1:0] rpm_val, spd_val;

  logic [CB-1:0] delta;
  logic          neg;
  logic [CB-1:0] mag;

  logic [OW-1:0] cnt_two, rpm_two, spd_two;

  assign item_acc = item_i.valid && item_i.ready;
  assign cpr_eff  = (cpr_q == '0) ? 16'd1 : cpr_q;
  assign div_done = rdiv_done && sdiv_done;
  assign scl_done = rscl_done && sscl_done;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q  <= CPR_RST;
      diam_q <= DIAM_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_CPR:  cpr_q  <= cfg_i.data.value;
        CFG_DIAM: diam_q <= cfg_i.data.value[9:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_acc) begin
          if (item_i.data.kind == KIND_SAMPLE && item_i.data.period_ms != '0) begin
            state_d = ST_DSTART;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_SWAIT;
      ST_SWAIT: begin
        if (scl_done) begin
          state_d = (cur_q == MIW'(NUM_MOTORS - 1)) ? ST_EMIT : ST_LOAD;
        end
      end
      ST_EMIT: begin
        if (!res_vld_q || res_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_rdy = 1'b0;
    div_go   = 1'b0;
    scl_go   = 1'b0;
    res_load = 1'b0;
    case (state_q)
      ST_IDLE:   item_rdy = 1'b1;
      ST_DSTART: div_go   = 1'b1;
      ST_LOAD:   scl_go   = 1'b1;
      ST_EMIT:   res_load = !res_vld_q || res_o.ready;
      default: ;
    endcase
  end

  assign item_i.ready = item_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      if (div_go) begin
        cur_q <= '0;
      end else if (state_q == ST_SWAIT && scl_done) begin
        cur_q <= cur_q + MIW'(1);
      end
    end
  end

  // hold sample operands
  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      d_q    <= DW'(cpr_eff) * DW'(item_i.data.period_ms);
      kspd_q <= KW'(diam_q) * PI_KSCALE;
    end
  end

  // motor state
  always_comb begin
    delta = cnt_q[cur_q] - prev_q[cur_q];
    neg   = delta[CB-1];
    mag   = neg ? (~delta + CB'(1)) : delta;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (item_acc) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        if (int'(item_i.data.motor) == i + 1) begin
          case (item_i.data.kind)
            KIND_EDGE:  cnt_q[i] <= item_i.data.b_level ? cnt_q[i] + CB'(1)
                                                        : cnt_q[i] - CB'(1);
            KIND_CLEAR: cnt_q[i] <= '0;
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        prev_q[i] <= '0;
        rpm_q[i]  <= '0;
        spd_q[i]  <= '0;
      end
    end else begin
      if (scl_go) begin
        prev_q[cur_q] <= cnt_q[cur_q];
      end
      if (state_q == ST_SWAIT && scl_done) begin
        rpm_q[cur_q] <= rpm_val;
        spd_q[cur_q] <= spd_val;
      end
    end
  end

  // arithmetic units
  qesm_div u_rdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (RPM_SCALE),
    .den_i   (d_q),
    .done_o  (rdiv_done),
    .quot_o  (q1r),
    .rem_o   (r1r)
  );

  qesm_div u_sdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (kspd_q),
    .den_i   (d_q),
    .done_o  (sdiv_done),
    .quot_o  (q1s),
    .rem_o   (r1s)
  );

  qesm_scale #(
    .MW (CB),
    .SH (0)
  ) u_rscl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scl_go),
    .neg_i   (neg),
    .mag_i   (mag),
    .q1_i    (q1r),
    .r1_i    (r1r),
    .den_i   (d_q),
    .done_o  (rscl_done),
    .val_o   (rpm_val)
  );

  qesm_scale #(
    .MW (CB),
    .SH (6)
  ) u_sscl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scl_go),
    .neg_i   (neg),
    .mag_i   (mag),
    .q1_i    (q1s),
    .r1_i    (r1s),
    .den_i   (d_q),
    .done_o  (sscl_done),
    .val_o   (spd_val)
  );

  // result beat
  if (NUM_MOTORS > 1) begin : g_two
    assign cnt_two = OW'(signed'(cnt_q[1]));
    assign rpm_two = rpm_q[1];
    assign spd_two = spd_q[1];
  end else begin : g_one
    assign cnt_two = '0;
    assign rpm_two = '0;
    assign spd_two = '0;
  end

  always_comb begin
    res_d.count_one = OW'(signed'(cnt_q[0]));
    res_d.count_two = cnt_two;
    res_d.rpm_one   = rpm_q[0];
    res_d.rpm_two   = rpm_two;
    res_d.speed_one = spd_q[0];
    res_d.speed_two = spd_two;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_load) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  // checks
  a_div_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DWAIT |-> d_q != '0)
    else $error("divide running with zero divisor");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdiv_done || sdiv_done) |-> (state_q == ST_DWAIT && rdiv_done == sdiv_done))
    else $error("divider finished outside its wait state or out of step");

  a_scl_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rscl_done || sscl_done) |-> (state_q == ST_SWAIT && rscl_done == sscl_done))
    else $error("scaler finished outside its wait state or out of step");

  a_res_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> $past(state_q == ST_EMIT))
    else $error("result loaded outside emit state");

endmodule

### tb/quadrature_encoder_speed_meter_unit_tb.sv
// Self-checking testbench for the two-motor encoder counter and speed meter.
`timescale 1ns / 1ps

module quadrature_encoder_speed_meter_unit_tb;
  import qesm_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int LONG_HOLD = 400;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 240;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam logic [CFG_IW-1:0] CFG_UNUSED_LO = 8'd2;
  localparam logic [CFG_IW-1:0] CFG_UNUSED_HI = 8'hFF;

  localparam longint unsigned RPM_K = 64'd15360000;
  localparam longint unsigned PI_Q14 = 64'd51472;
  localparam longint unsigned QCAP = 64'd1 << 40;
  localparam longint unsigned QCLIP = 64'd1 << 34;

  logic clk_i;
  logic rst_ni;

  qesm_stream_if #(.T(in_item_t)) item_if ();
  qesm_stream_if #(.T(cfg_beat_t)) cfg_if ();
  qesm_stream_if #(.T(out_item_t)) res_if ();

  quadrature_encoder_speed_meter_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  in_item_t  pending_items[$];
  out_item_t readings_due[$];

  logic [15:0] cpr_q;
  logic [9:0]  diam_q;
  logic [31:0] pulse_q [2];
  logic [31:0] last_q  [2];
  logic [31:0] rpm_q   [2];
  logic [31:0] speed_q [2];

  string field_names [6] = '{"count_one", "count_two", "rpm_one", "rpm_two",
                             "speed_one", "speed_two"};

  int mismatch_count;
  int items_taken;
  int readings_checked;
  int samples_taken;
  int saturated_seen;
  int settings_used;
  int cycle_count;
  int tx_gap;
  int rx_hold_left;
  int hold_req;
  int hold_ack;
  bit quiet_tail;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned scaled_div(longint unsigned mag, longint unsigned k,
                                                 longint unsigned d, int unsigned sh);
    longint unsigned q1;
    longint unsigned r1;
    longint unsigned total;
    q1 = k / d;
    r1 = k % d;
    if (q1 != 0 && mag > QCAP / q1) return QCLIP;
    total = mag * q1 + (mag * r1) / d;
    if (total > QCAP) return QCLIP;
    return total >> sh;
  endfunction

  function automatic logic [31:0] sat32(bit neg, longint unsigned mag);
    if (neg) begin
      if (mag >= 64'h8000_0000) return OUT_MIN;
      return ~mag[31:0] + 32'd1;
    end
    if (mag > 64'h7FFF_FFFF) return OUT_MAX;
    return mag[31:0];
  endfunction

  function automatic out_item_t advance_meter(in_item_t it);
    out_item_t r;
    longint unsigned span;
    longint unsigned kspd;
    longint unsigned mag;
    logic [31:0] delta;
    logic [31:0] negd;
    bit neg;
    int idx;
    idx = int'(it.motor) - 1;
    case (it.kind)
      KIND_EDGE: begin
        if (it.motor == 2'd1 || it.motor == 2'd2) begin
          pulse_q[idx] = it.b_level ? pulse_q[idx] + 32'd1 : pulse_q[idx] - 32'd1;
        end
      end
      KIND_CLEAR: begin
        if (it.motor == 2'd1 || it.motor == 2'd2) begin
          pulse_q[idx] = '0;
        end
      end
      KIND_SAMPLE: begin
        if (it.period_ms != 0) begin
          samples_taken++;
          span = ((cpr_q == 0) ? 64'd1 : 64'(cpr_q)) * 64'(it.period_ms);
          kspd = PI_Q14 * 64'(diam_q) * 64'd1000;
          for (int i = 0; i < 2; i++) begin
            delta = pulse_q[i] - last_q[i];
            neg = delta[31];
            negd = -delta;
            mag = neg ? 64'(negd) : 64'(delta);
            last_q[i] = pulse_q[i];
            rpm_q[i] = sat32(neg, scaled_div(mag, RPM_K, span, 0));
            speed_q[i] = sat32(neg, scaled_div(mag, kspd, span, 6));
            if (rpm_q[i] == OUT_MAX || rpm_q[i] == OUT_MIN ||
                speed_q[i] == OUT_MAX || speed_q[i] == OUT_MIN) begin
              saturated_seen++;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.count_one = pulse_q[0];
    r.count_two = pulse_q[1];
    r.rpm_one = rpm_q[0];
    r.rpm_two = rpm_q[1];
    r.speed_one = speed_q[0];
    r.speed_two = speed_q[1];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < 40) $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // check results, then predict from accepted beats
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    out_item_t got;
    out_item_t want;
    logic [31:0] got_f;
    logic [31:0] want_f;
    if (!rst_ni) begin
      cpr_q <= CPR_RST;
      diam_q <= DIAM_RST;
      for (int i = 0; i < 2; i++) begin
        pulse_q[i] <= '0;
        last_q[i] <= '0;
        rpm_q[i] <= '0;
        speed_q[i] <= '0;
      end
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (readings_due.size() == 0) begin
          report_mismatch($sformatf("unexpected reading %h", got));
        end else begin
          want = readings_due.pop_front();
          for (int k = 0; k < 6; k++) begin
            got_f = got[191 - 32 * k -: 32];
            want_f = want[191 - 32 * k -: 32];
            if (got_f !== want_f) begin
              report_mismatch($sformatf("reading %0d %s: got %h want %h",
                                        readings_checked, field_names[k], got_f, want_f));
            end
          end
          readings_checked++;
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          CFG_CPR:  cpr_q = cfg_if.data.value;
          CFG_DIAM: diam_q = cfg_if.data.value[9:0];
          default: begin
          end
        endcase
      end
      if (item_if.valid && item_if.ready) begin
        readings_due.push_back(advance_meter(item_if.data));
        items_taken++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
      tx_gap <= 0;
    end else if (item_if.valid && !item_if.ready) begin
      // hold the beat
    end else if (tx_gap != 0) begin
      tx_gap <= tx_gap - 1;
      item_if.valid <= 1'b0;
    end else if (pending_items.size() != 0) begin
      if (!quiet_tail && $urandom_range(0, 99) < 6) begin
        tx_gap <= $urandom_range(0, 17);
        item_if.valid <= 1'b0;
      end else begin
        item_if.valid <= 1'b1;
        item_if.data <= pending_items.pop_front();
      end
    end else begin
      item_if.valid <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rx_hold_left <= 0;
      hold_ack <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      rx_hold_left <= LONG_HOLD;
      res_if.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      res_if.ready <= (rx_hold_left == 1);
    end else if (!quiet_tail && $urandom_range(0, 99) < 7) begin
      rx_hold_left <= $urandom_range(1, 18);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles, %0d readings outstanding",
               cycle_count, readings_due.size());
      $display("quadrature_encoder_speed_meter_unit verification failed");
      $finish;
    end
  end

  function automatic void queue_item(logic [1:0] kind, logic [1:0] motor, logic b,
                                     logic [15:0] period);
    in_item_t it;
    it.kind = kind;
    it.motor = motor;
    it.b_level = b;
    it.period_ms = period;
    pending_items.push_back(it);
  endfunction

  function automatic logic [15:0] pick_period();
    int p;
    p = $urandom_range(0, 19);
    if (p < 14) return 16'($urandom_range(1, 10));
    if (p < 17) return 16'($urandom_range(1, 65535));
    if (p < 19) return 16'hFFFF;
    return 16'd0;
  endfunction

  // mostly edge bursts closed by a sample, then clears and noise
  function automatic void queue_random_phase(int n_items);
    int made;
    int r;
    int len;
    int up_bias;
    int m;
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m = $urandom_range(1, 2);
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(140, 220) : $urandom_range(0, 10);
        up_bias = $urandom_range(0, 100);
        repeat (len) begin
          queue_item(KIND_EDGE, ($urandom_range(0, 99) < 85) ? 2'(m) : 2'(3 - m),
                     $urandom_range(0, 99) < up_bias, 16'($urandom));
          made++;
        end
        queue_item(KIND_SAMPLE, 2'($urandom), 1'($urandom), pick_period());
      end else if (r < 80) begin
        queue_item(KIND_CLEAR, 2'($urandom), 1'($urandom), 16'($urandom));
      end else if (r < 95) begin
        queue_item(2'($urandom), 2'($urandom), 1'($urandom), 16'($urandom));
      end else begin
        queue_item(($urandom_range(0, 1) == 0) ? KIND_NOP : KIND_SAMPLE, 2'($urandom),
                   1'($urandom), 16'd0);
      end
      made++;
    end
  endfunction

  task automatic program_reg(logic [CFG_IW-1:0] index, logic [CFG_DW-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: index, value: value};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || item_if.valid || readings_due.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] cpr;
    logic [15:0] diam;
    rst_ni = 1'b0;
    item_if.valid = 1'b0;
    item_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    res_if.ready = 1'b0;
    hold_req = 0;
    quiet_tail = 1'b0;
    cycle_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_item(KIND_EDGE, 2'd1, 1'b1, 16'h0000);
    queue_item(KIND_EDGE, 2'd1, 1'b1, 16'hFFFF);
    queue_item(KIND_EDGE, 2'd2, 1'b0, 16'h0000);
    queue_item(KIND_EDGE, 2'd0, 1'b1, 16'h1234);
    queue_item(KIND_EDGE, 2'd3, 1'b0, 16'h0001);
    queue_item(KIND_NOP, 2'd1, 1'b1, 16'hFFFF);
    queue_item(KIND_SAMPLE, 2'd1, 1'b0, 16'd0);
    queue_item(KIND_SAMPLE, 2'd0, 1'b1, 16'd1);
    queue_item(KIND_EDGE, 2'd2, 1'b0, 16'h0000);
    queue_item(KIND_EDGE, 2'd2, 1'b0, 16'h0000);
    queue_item(KIND_SAMPLE, 2'd3, 1'b0, 16'hFFFF);
    queue_item(KIND_CLEAR, 2'd1, 1'b0, 16'h0000);
    queue_item(KIND_CLEAR, 2'd0, 1'b1, 16'h0000);
    queue_item(KIND_CLEAR, 2'd3, 1'b1, 16'h0000);
    queue_item(KIND_SAMPLE, 2'd1, 1'b0, 16'd7);
    queue_item(KIND_EDGE, 2'd1, 1'b0, 16'h0000);
    queue_item(KIND_SAMPLE, 2'd2, 1'b1, 16'd3);
    queue_item(KIND_CLEAR, 2'd2, 1'b0, 16'hA5A5);
    queue_item(KIND_SAMPLE, 2'd1, 1'b0, 16'h5A5A);
    queue_item(KIND_NOP, 2'd0, 1'b0, 16'd0);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin cpr = 16'd1; diam = 16'd1023; end
        1: begin cpr = 16'hFFFF; diam = 16'd1; end
        2: begin cpr = 16'd0; diam = 16'd0; end
        3: begin cpr = CPR_RST; diam = 16'(DIAM_RST); end
        default: begin
          cpr = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 64))
                                             : 16'($urandom_range(1, 65535));
          diam = 16'($urandom_range(1, 1023));
          if (ph == 5) diam = {6'($urandom_range(1, 63)), diam[9:0]};
        end
      endcase
      program_reg(CFG_CPR, cpr);
      program_reg(CFG_DIAM, diam);
      if (ph == 2) begin
        program_reg(CFG_UNUSED_LO, 16'($urandom));
        program_reg(CFG_UNUSED_HI, 16'($urandom));
      end
      settings_used++;
      if (ph == PHASES - 1) quiet_tail = 1'b1;
      queue_random_phase(PHASE_ITEMS);
      if (ph == 1 || ph == 4) hold_req++;
      settle();
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d items and %0d readings over %0d register settings",
             items_taken, readings_checked, settings_used + 1);
    $display("%0d speed samples taken, %0d motor readings hit a limit",
             samples_taken, saturated_seen);
    if (mismatch_count == 0) begin
      $display("quadrature_encoder_speed_meter_unit verification clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("quadrature_encoder_speed_meter_unit verification failed");
    end
    $finish;
  end

endmodule
